### design/rational_arithmetic_unit_core_defines.svh
// Assertion macros for the rational arithmetic unit checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
// Implication checked on every edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/rau_pkg.sv
//------------------------------------------------------------------------------
// rau_pkg
// Shared constants and types for the rational arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  localparam int WIDTH_DEF = 32;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;
  localparam logic [2:0] ACT_CMP = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
endpackage
`default_nettype wire

### design/rau_mul.sv
//------------------------------------------------------------------------------
// rau_mul
// Shift-add multiplier, one bit per cycle, unsigned 32x32 to 64.
//------------------------------------------------------------------------------
`default_nettype none
module rau_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  output logic             done,
  output logic [63:0]      prod
);
  logic [31:0] mplr;
  logic [63:0] mcand;
  logic [5:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        mplr  <= op_b;
        mcand <= {32'd0, op_a};
        prod  <= '0;
        cnt   <= 6'd0;
      end else if (busy) begin
        if (mplr[0]) prod <= prod + mcand;
        mplr  <= mplr >> 1;
        mcand <= mcand << 1;
        cnt   <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/rau_div.sv
//------------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle, 64 by 64 bits.
//------------------------------------------------------------------------------
`default_nettype none
module rau_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quot
);
  logic [6:0]  cnt;
  logic        busy;
  logic [63:0] rem;
  logic [64:0] trial;

  assign trial = {rem, quot[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quot <= dividend;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem  <= trial[63:0];
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= {rem[62:0], quot[63]};
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### design/rational_arithmetic_unit_core.sv
//------------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Exact add, subtract, multiply, divide, negate and compare of fractions.
//------------------------------------------------------------------------------
// One beat in, one beat out. Each item is handled alone: cross products are
// formed by a bit-serial multiplier (up to three per item), the gcd is found
// by binary gcd on the 64-bit numerator and denominator (a load step in
// S_GLD, then one shift or compare and subtract per cycle in S_GCD), and the
// two reductions use a one-bit-per-cycle divider. Compare skips the gcd and
// the reductions, negate skips the multiplier, a zero result skips the
// reduction, and error and unused codes go straight to the result stage S_FIN.
// s_tready is high only while the core is idle; the result beat waits in an
// output register until m_tready, and the core is idle again in the cycle
// after the beat is taken.
`default_nettype none
module rational_arithmetic_unit_core #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // action[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98]
  input  wire logic [135:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // res_num[31:0], res_den[62:32], is_less[63], is_equal[64],
  // is_greater[65], status[67:66]
  output logic [71:0]       m_tdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_COMB, S_GLD, S_GCD, S_D1, S_D2, S_FIN, S_OUT
  } state_t;

  localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);
  localparam logic [63:0] DMASK = LIM - 64'd1;

  state_t state;
  logic [2:0] act;
  logic an_s, bn_s, rs;
  logic [31:0] an, bn, ad, bd;
  logic [63:0] p1, p2, rn, rd, gx, gy;
  logic [6:0] gk;
  logic [1:0] st;
  logic lt, eq, gt;

  logic mstart, mdone, dstart, ddone;
  logic [31:0] ma, mb;
  logic [63:0] mprod, dnd, dsr, dq;

  rau_mul u_mul (.clk, .rst, .start(mstart), .op_a(ma), .op_b(mb),
                 .done(mdone), .prod(mprod));
  rau_div u_div (.clk, .rst, .start(dstart), .dividend(dnd), .divisor(dsr),
                 .done(ddone), .quot(dq));

  // Input field decode, sign-magnitude at WIDTH.
  logic [2:0]  i_act;
  logic [WIDTH-1:0] i_an, i_bn;
  logic [31:0] i_anm, i_bnm, i_ad, i_bd;
  always_comb begin
    i_act = s_tdata[2:0];
    i_an  = s_tdata[3 +: WIDTH];
    i_bn  = s_tdata[66 +: WIDTH];
    i_anm = 32'(i_an[WIDTH-1] ? (~i_an + 1'b1) : i_an);
    i_bnm = 32'(i_bn[WIDTH-1] ? (~i_bn + 1'b1) : i_bn);
    i_ad  = 32'(s_tdata[35 +: WIDTH-1]);
    i_bd  = 32'(s_tdata[98 +: WIDTH-1]);
  end

  // Signed combine of the cross products.
  logic ls, rsg;
  always_comb begin
    ls  = an_s && (p1 != 64'd0);
    rsg = (bn_s && (p2 != 64'd0)) != (act == rau_pkg::ACT_SUB);
  end

  assign s_tready = (state == S_IDLE);
  // The divider samples its operands on the registered dstart, while the state already selects them.
  assign dnd = (state == S_D1) ? rn : rd;
  assign dsr = gx;

  logic ovf;
  assign ovf = (rd > DMASK) || (rs ? (rn > LIM) : (rn >= LIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      mstart   <= 1'b0;
      dstart   <= 1'b0;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act <= i_act; an <= i_anm; bn <= i_bnm; ad <= i_ad; bd <= i_bd;
            an_s <= i_an[WIDTH-1]; bn_s <= i_bn[WIDTH-1];
            lt <= 1'b0; eq <= 1'b0; gt <= 1'b0; st <= rau_pkg::ST_OK;
            rs <= 1'b0; rn <= '0; rd <= 64'd1;
            if (i_act > rau_pkg::ACT_CMP) begin
              state <= S_FIN;
            end else if (i_ad == 32'd0 || (i_act != rau_pkg::ACT_NEG && i_bd == 32'd0) ||
                         (i_act == rau_pkg::ACT_DIV && i_bnm == 32'd0)) begin
              st <= rau_pkg::ST_DIV0;
              state <= S_FIN;
            end else if (i_act == rau_pkg::ACT_NEG) begin
              rs <= ~i_an[WIDTH-1]; rn <= {32'd0, i_anm}; rd <= {32'd0, i_ad};
              state <= S_COMB;
            end else begin
              ma <= i_anm;
              mb <= (i_act == rau_pkg::ACT_MUL) ? i_bnm : i_bd;
              mstart <= 1'b1;
              state <= S_M1;
            end
          end
        end
        S_M1: if (mdone) begin
          p1 <= mprod;
          ma <= (act == rau_pkg::ACT_DIV) ? ad : bn;
          mb <= (act == rau_pkg::ACT_DIV) ? bn : ad;
          mstart <= 1'b1;
          state <= S_M2;
        end
        S_M2: if (mdone) begin
          p2 <= mprod;
          if (act == rau_pkg::ACT_CMP) begin
            state <= S_COMB;
          end else begin
            ma <= ad; mb <= bd;
            mstart <= (act != rau_pkg::ACT_DIV);
            state <= (act == rau_pkg::ACT_DIV) ? S_COMB : S_M3;
          end
        end
        S_M3: if (mdone) begin
          rd <= mprod;
          state <= S_COMB;
        end
        S_COMB: begin
          // Form signed result numerator/denominator or the compare flags, then start the gcd or finish a compare.
          case (act)
            rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
              if (ls == rsg) begin
                rs <= ls; rn <= p1 + p2;
              end else if (p1 >= p2) begin
                rs <= ls; rn <= p1 - p2;
              end else begin
                rs <= rsg; rn <= p2 - p1;
              end
            end
            rau_pkg::ACT_MUL: begin
              rs <= an_s != bn_s; rn <= p1;
            end
            rau_pkg::ACT_DIV: begin
              rs <= an_s != bn_s; rn <= p1; rd <= p2;
            end
            rau_pkg::ACT_CMP: begin
              if ((p1 == 64'd0 || !an_s) != (p2 == 64'd0 || !bn_s)) begin
                lt <= an_s && p1 != 64'd0; gt <= !(an_s && p1 != 64'd0);
              end else if (p1 == p2) begin
                eq <= 1'b1;
              end else begin
                lt <= (an_s && p1 != 64'd0) ? (p1 > p2) : (p1 < p2);
                gt <= (an_s && p1 != 64'd0) ? (p1 < p2) : (p1 > p2);
              end
            end
            default: ;
          endcase
          gk <= '0;
          state <= (act == rau_pkg::ACT_CMP) ? S_FIN : S_GLD;
        end
        S_GLD: begin
          // Load the gcd operands; a zero numerator needs no reduction.
          gx <= rn; gy <= rd;
          if (rn == 64'd0) begin
            rs <= 1'b0; rd <= 64'd1; state <= S_FIN;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // Binary gcd on (gx, gy); done when gy reaches zero.
          if (gy == 64'd0) begin
            gx <= gx << gk;
            dstart <= 1'b1;
            state <= S_D1;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1; gy <= gy >> 1; gk <= gk + 7'd1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx == gy) begin
            gy <= '0;
          end else if (gx > gy) begin
            gx <= gx - gy;
          end else begin
            gy <= gy - gx;
          end
        end
        S_D1: if (ddone) begin
          rn <= dq;
          dstart <= 1'b1;
          state <= S_D2;
        end
        S_D2: if (ddone) begin
          rd <= dq;
          state <= S_FIN;
        end
        S_FIN: begin
          if (st == rau_pkg::ST_OK && ovf) st <= rau_pkg::ST_OVF;
          state <= S_OUT;
          m_tvalid <= 1'b1;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic ok;
  logic [31:0] onum;
  assign ok = (st == rau_pkg::ST_OK);
  assign onum = 32'(rs ? (64'd0 - rn) : rn);
  always_comb begin
    m_tdata = '0;
    m_tdata[31:0]  = ok ? onum : 32'd0;
    m_tdata[62:32] = ok ? 31'(rd) : 31'd0;
    m_tdata[63]    = ok & lt;
    m_tdata[64]    = ok & eq;
    m_tdata[65]    = ok & gt;
    m_tdata[67:66] = st;
  end
endmodule
`default_nettype wire

### design/rau_checker.sv
//------------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
//------------------------------------------------------------------------------
`default_nettype none
`include "rational_arithmetic_unit_core_defines.svh"
module rau_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [71:0]  m_tdata
);
  // One item at a time: never ready while a result is pending.
  `RAU_ASSERT_IMP(a_excl, clk, rst, m_tvalid, !s_tready, "ready with result pending")
  // Accepted input is followed by busy.
  `RAU_ASSERT_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "still ready")
  // Error results carry zero payload and no flags.
  `RAU_ASSERT_IMP(a_err, clk, rst, m_tvalid && m_tdata[67:66] != rau_pkg::ST_OK,
    m_tdata[65:0] == 66'd0, "error beat with payload")
  // At most one compare flag.
  `RAU_ASSERT_IMP(a_flags, clk, rst, m_tvalid, $onehot0(m_tdata[65:63]), "flags clash")
endmodule
bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

### tb/rational_arithmetic_unit_core_checker.sv
//------------------------------------------------------------------------------
// rational_arithmetic_unit_core_checker
// Watches both stream channels, predicts each result beat from the accepted
// input beat and compares field by field in order.
//------------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [135:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [71:0]  m_tdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_greater;
    logic        is_equal;
    logic        is_less;
    logic [30:0] res_den;
    logic [31:0] res_num;
  } fraction_result_t;

  fraction_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_result_t compute_fraction(input logic [135:0] d);
    logic [2:0]  act;
    logic        an_s, bn_s, rs, ls, rsg;
    logic [63:0] an, bn, ad, bd, rn, rd, l, r, g;
    logic [1:0]  st;
    fraction_result_t res;
    act  = d[2:0];
    an_s = d[34];
    an   = an_s ? 64'(-$signed({32'hffffffff, d[34:3]})) : {32'd0, d[34:3]};
    ad   = {33'd0, d[65:35]};
    bn_s = d[97];
    bn   = bn_s ? 64'(-$signed({32'hffffffff, d[97:66]})) : {32'd0, d[97:66]};
    bd   = {33'd0, d[128:98]};
    rs = 0; rn = 0; rd = 1; st = rau_pkg::ST_OK;
    res = '0;
    if (act > rau_pkg::ACT_CMP) begin
      rn = 0;
    end else if (ad == 0 || (act != rau_pkg::ACT_NEG && bd == 0)) begin
      st = rau_pkg::ST_DIV0;
    end else if (act == rau_pkg::ACT_DIV && bn == 0) begin
      st = rau_pkg::ST_DIV0;
    end else if (act == rau_pkg::ACT_CMP) begin
      l = an * bd;
      r = bn * ad;
      ls = an_s && l != 0;
      rsg = bn_s && r != 0;
      if (ls != rsg) begin
        res.is_less = ls;
        res.is_greater = rsg;
      end else if (l == r) res.is_equal = 1;
      else if ((l < r) != ls) res.is_less = 1;
      else res.is_greater = 1;
    end else begin
      case (act)
        rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
          l = an * bd;
          r = bn * ad;
          ls = an_s && l != 0;
          rsg = (bn_s && r != 0) != (act == rau_pkg::ACT_SUB);
          if (ls == rsg) begin
            rs = ls; rn = l + r;
          end else if (l >= r) begin
            rs = ls; rn = l - r;
          end else begin
            rs = rsg; rn = r - l;
          end
          rd = ad * bd;
        end
        rau_pkg::ACT_MUL: begin
          rs = an_s != bn_s; rn = an * bn; rd = ad * bd;
        end
        rau_pkg::ACT_DIV: begin
          rs = an_s != bn_s; rn = an * bd; rd = ad * bn;
        end
        default: begin
          rs = !an_s; rn = an; rd = ad;
        end
      endcase
      if (rn == 0) begin
        rs = 0; rd = 1;
      end else begin
        g = gcd64(rn, rd);
        rn = rn / g;
        rd = rd / g;
      end
      if (rd > 64'h7fffffff || (rs ? rn > 64'h80000000 : rn >= 64'h80000000))
        st = rau_pkg::ST_OVF;
    end
    if (st != rau_pkg::ST_OK) begin
      res = '0;
    end else begin
      res.res_num = rs ? 32'(-rn) : rn[31:0];
      res.res_den = rd[30:0];
    end
    res.status = st;
    return res;
  endfunction

  always @(posedge clk) begin
    fraction_result_t got, want;
    if (rst) begin
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(compute_fraction(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[67:0];
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display({"mismatch: exp num %h den %h lt %b eq %b gt %b st %0d",
                        " | got num %h den %h lt %b eq %b gt %b st %0d"},
                       want.res_num, want.res_den, want.is_less, want.is_equal,
                       want.is_greater, want.status, got.res_num, got.res_den,
                       got.is_less, got.is_equal, got.is_greater, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### tb/rational_arithmetic_unit_core_tb.sv
//------------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb
// Drives directed and random fraction beats through the core under several
// idle/stall mixes, including one long output hold-off; the checker scores.
//------------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [71:0]  m_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off_cycles = 0;
  int           quiet_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  rational_arithmetic_unit_core uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  rational_arithmetic_unit_core_checker checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .fail_count, .pending
  );

  // Receiver: random stalls, or a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Valid stays up between back-to-back beats and drops only while idling.
  task automatic send_beat(input logic [2:0] act, input logic [31:0] an,
                           input logic [30:0] ad, input logic [31:0] bn,
                           input logic [30:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tdata  <= {7'd0, bd, bn, ad, an, act};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(5))
      0: return 32'h80000000 + $urandom_range(3);
      1: return 32'h7fffffff - $urandom_range(3);
      2: return 32'(int'($urandom_range(40)) - 20);
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(4))
      0: return 31'(32'h7fffffff - $urandom_range(3));
      1: return 31'($urandom_range(12) + 1);
      2: return ($urandom_range(19) == 0) ? 31'd0 : 31'd1;
      default: return 31'($urandom) | 31'd1;
    endcase
  endfunction

  task automatic random_beats(input int count);
    logic [2:0] act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(30) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      send_beat(act, rand_num(), rand_den(), rand_num(), rand_den());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: every action, field extremes, zero divisor/denominator,
    // overflow, negating the most negative value, unreduced input, unused codes.
    send_beat(rau_pkg::ACT_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_beat(rau_pkg::ACT_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
    send_beat(rau_pkg::ACT_MUL, 32'hfffffffe, 31'd4, 32'd6, 31'd9);
    send_beat(rau_pkg::ACT_DIV, 32'd3, 31'd4, 32'hfffffffd, 31'd8);
    send_beat(rau_pkg::ACT_DIV, 32'd3, 31'd4, 32'd0, 31'd8);
    send_beat(rau_pkg::ACT_NEG, 32'h80000000, 31'd1, 32'd0, 31'd0);
    send_beat(rau_pkg::ACT_NEG, 32'h7fffffff, 31'h7fffffff, 32'hffffffff, 31'h7fffffff);
    send_beat(rau_pkg::ACT_CMP, 32'd1, 31'd3, 32'd2, 31'd6);
    send_beat(rau_pkg::ACT_CMP, 32'hffffffff, 31'd3, 32'd1, 31'd6);
    send_beat(rau_pkg::ACT_CMP, 32'd5, 31'd3, 32'd1, 31'd6);
    send_beat(rau_pkg::ACT_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
    send_beat(rau_pkg::ACT_SUB, 32'd1, 31'd1, 32'd1, 31'd0);
    send_beat(rau_pkg::ACT_NEG, 32'd1, 31'd0, 32'd1, 31'd1);
    send_beat(rau_pkg::ACT_MUL, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1);
    send_beat(rau_pkg::ACT_MUL, 32'h80000000, 31'd1, 32'h80000000, 31'h7fffffff);
    send_beat(rau_pkg::ACT_ADD, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7ffffffe);
    send_beat(rau_pkg::ACT_ADD, 32'd6, 31'd4, 32'd0, 31'd10);
    send_beat(rau_pkg::ACT_DIV, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7fffffff);
    send_beat(3'd6, 32'd1, 31'd1, 32'd1, 31'd1);
    send_beat(3'd7, 32'hffffffff, 31'h7fffffff, 32'hffffffff, 31'h7fffffff);

    random_beats(300);
    send_idle_pct = 51; random_beats(250);
    send_idle_pct = 0; recv_stall_pct = 51; random_beats(250);
    // Long hold-off while the sender keeps offering.
    hold_off_cycles = 3000; random_beats(100);
    send_idle_pct = 33; recv_stall_pct = 33; random_beats(250);
    send_idle_pct = 0; recv_stall_pct = 0; random_beats(250);
    s_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+design
design/rau_pkg.sv
design/rau_mul.sv
design/rau_div.sv
design/rational_arithmetic_unit_core.sv
design/rau_checker.sv
tb/rational_arithmetic_unit_core_checker.sv
tb/rational_arithmetic_unit_core_tb.sv
